### design/wws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and helpers for the whitespace word splitter.
// Used by wws_queue and whitespace_word_splitter; depends on nothing else.

package wws_pkg;

  // Width of the internal word byte counter, word counter and longest length.
  localparam int COUNT_BITS = 16;

  // Result queue depth; an input beat may push two results.
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_W    = 16;
  localparam int CP_W     = 21;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;

  // Configuration register indexes.
  localparam logic CFG_BUFFER_BYTES = 1'b0;
  localparam logic CFG_BUFFER_SLOTS = 1'b1;

  // Input kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Result events.
  localparam logic [1:0] EV_CHAR  = 2'd0;
  localparam logic [1:0] EV_WORD  = 2'd1;
  localparam logic [1:0] EV_SPACE = 2'd2;
  localparam logic [1:0] EV_DONE  = 2'd3;

  // Character codes.
  localparam logic [CP_W-1:0] CP_TAB   = 21'h9;
  localparam logic [CP_W-1:0] CP_LF    = 21'hA;
  localparam logic [CP_W-1:0] CP_VT    = 21'hB;
  localparam logic [CP_W-1:0] CP_FF    = 21'hC;
  localparam logic [CP_W-1:0] CP_CR    = 21'hD;
  localparam logic [CP_W-1:0] CP_SPACE = 21'h20;
  localparam logic [CP_W-1:0] CP_MAX1  = 21'h7F;
  localparam logic [CP_W-1:0] CP_MAX2  = 21'h7FF;
  localparam logic [CP_W-1:0] CP_MAX3  = 21'hFFFF;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [1:0]      event_res;
    logic            stored;
    logic [15:0]     word_index;
    logic [15:0]     byte_offset;
    logic [2:0]      byte_length;
    logic [CP_W-1:0] char_value;
    logic [15:0]     words_found;
    logic [15:0]     longest_word;
    logic            last;
  } result_t;

  // Saturating add of a small increment to a counter.
  function automatic count_t sat_add(count_t a, logic [2:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // Low 16 bits of a counter, whatever its width.
  function automatic logic [15:0] low16(count_t a);
    logic [31:0] w;
    w = 32'(a);
    return w[15:0];
  endfunction

  function automatic logic is_space(logic [CP_W-1:0] cp);
    return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_VT) ||
           (cp == CP_FF) || (cp == CP_CR) || (cp == CP_SPACE);
  endfunction

  function automatic logic [2:0] utf8_size(logic [CP_W-1:0] cp);
    if (cp > CP_MAX3) return 3'd4;
    if (cp > CP_MAX2) return 3'd3;
    if (cp > CP_MAX1) return 3'd2;
    return 3'd1;
  endfunction

endpackage

`default_nettype wire

### design/whitespace_word_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the whitespace word splitter: word state, result building and
// the configuration registers. Depends on wws_pkg and wws_queue.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser kind, tdata code point
//  m_*      | out       | m_tvalid/m_tready | tuser event, tdata result, tlast
//  cfg_*    | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// One input beat is taken per cycle while s_tready is high; its results are built
// in the same cycle and land in a four-entry result queue, so the output is always
// registered. An end of string that closes an open word gives two output beats,
// all others give one; the sustained rate is therefore set by the output side.
// s_tready is high while the queue has room for two results, so a stalled
// output holds at most four results before input stops.

module whitespace_word_splitter (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [wws_pkg::IN_DATA_W-1:0]     s_tdata,   // [20:0] code_point, [23:21] zero
  input  wire                               s_tuser,   // [0] kind
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [wws_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] stored, [16:1] word_index,
                                                       // [32:17] byte_offset,
                                                       // [35:33] byte_length,
                                                       // [56:36] char_value,
                                                       // [72:57] words_found,
                                                       // [88:73] longest_word, rest zero
  output logic [1:0]                        m_tuser,   // [1:0] event_res
  output logic                              m_tlast,   // last
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire                               cfg_index,
  input  wire  [wws_pkg::CFG_W-1:0]         cfg_data
);
  import wws_pkg::*;

  logic [CFG_W-1:0] buffer_bytes;
  logic [CFG_W-1:0] buffer_slots;

  logic   inside_word;
  count_t word_bytes;
  count_t word_count;
  count_t longest_seen;

  logic   inside_word_next;
  count_t word_bytes_next;
  count_t word_count_next;
  count_t longest_seen_next;

  logic            accept;
  logic [CP_W-1:0] cp;
  logic            space;
  logic [2:0]      size;
  count_t          bytes_added;
  count_t          total;
  count_t          longest_after;
  count_t          count_after;
  logic [15:0]     term_offset;
  logic            term_stored;
  logic            char_stored;

  result_t word_res;
  result_t res0;
  result_t res1;
  logic    push1;
  result_t head;
  logic    q_not_empty;
  logic    q_room2;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = q_room2;
  assign cp        = s_tdata[CP_W-1:0];
  assign space     = is_space(cp);
  assign size      = utf8_size(cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= CFG_W'(64);
      buffer_slots <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUFFER_BYTES: buffer_bytes <= cfg_data;
        CFG_BUFFER_SLOTS: buffer_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  // Word end: terminator at min(bytes, length - 1), nothing when length is zero.
  always_comb begin
    total         = sat_add(word_bytes, 3'd1);
    longest_after = (total > longest_seen) ? total : longest_seen;
    count_after   = sat_add(word_count, 3'd1);
    term_stored   = (32'(word_count) < 32'(buffer_slots)) && (buffer_bytes != '0);
    if (buffer_bytes == '0) begin
      term_offset = '0;
    end else if (32'(word_bytes) >= 32'(buffer_bytes)) begin
      term_offset = buffer_bytes - 16'd1;
    end else begin
      term_offset = low16(word_bytes);
    end
    bytes_added = sat_add(word_bytes, size);
    char_stored = (32'(word_count) < 32'(buffer_slots)) &&
                  (32'(bytes_added) < 32'(buffer_bytes));

    word_res              = '0;
    word_res.event_res    = EV_WORD;
    word_res.stored       = term_stored;
    word_res.word_index   = low16(word_count);
    word_res.byte_offset  = term_offset;
    word_res.last         = 1'b1;
  end

  always_comb begin
    res0              = '0;
    res1              = '0;
    push1             = 1'b0;
    inside_word_next  = inside_word;
    word_bytes_next   = word_bytes;
    word_count_next   = word_count;
    longest_seen_next = longest_seen;
    if (s_tuser == KIND_END) begin
      // Done result carries the counts after any word that it closes.
      res1.event_res    = EV_DONE;
      res1.last         = 1'b1;
      if (inside_word) begin
        res0              = word_res;
        res0.last         = 1'b0;
        res1.words_found  = low16(count_after);
        res1.longest_word = low16(longest_after);
        push1             = 1'b1;
      end else begin
        res0              = res1;
        res0.words_found  = low16(word_count);
        res0.longest_word = low16(longest_seen);
      end
      inside_word_next  = 1'b0;
      word_bytes_next   = '0;
      word_count_next   = '0;
      longest_seen_next = '0;
    end else if (space) begin
      if (inside_word) begin
        res0              = word_res;
        inside_word_next  = 1'b0;
        word_bytes_next   = '0;
        word_count_next   = count_after;
        longest_seen_next = longest_after;
      end else begin
        res0.event_res   = EV_SPACE;
        res0.word_index  = low16(word_count);
        res0.byte_offset = low16(word_bytes);
        res0.char_value  = cp;
        res0.last        = 1'b1;
      end
    end else begin
      res0.event_res   = EV_CHAR;
      res0.stored      = char_stored;
      res0.word_index  = low16(word_count);
      res0.byte_offset = low16(word_bytes);
      res0.byte_length = size;
      res0.char_value  = cp;
      res0.last        = 1'b1;
      inside_word_next = 1'b1;
      word_bytes_next  = bytes_added;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word  <= 1'b0;
      word_bytes   <= '0;
      word_count   <= '0;
      longest_seen <= '0;
    end else if (accept) begin
      inside_word  <= inside_word_next;
      word_bytes   <= word_bytes_next;
      word_count   <= word_count_next;
      longest_seen <= longest_seen_next;
    end
  end

  wws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (accept),
    .data0     (res0),
    .push1     (push1),
    .data1     (res1),
    .pop       (m_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .room2     (q_room2)
  );

  assign m_tvalid = q_not_empty;
  assign m_tuser  = head.event_res;
  assign m_tlast  = head.last;
  assign m_tdata  = {7'd0, head.longest_word, head.words_found, head.char_value,
                     head.byte_length, head.byte_offset, head.word_index, head.stored};

  // An open word always holds at least one byte.
  a_open_word_bytes: assert property (@(posedge clk) disable iff (rst)
    inside_word |-> (word_bytes != '0))
    else $error("open word with zero bytes");

  // A longest length is only recorded when a word has been counted.
  a_longest_needs_word: assert property (@(posedge clk) disable iff (rst)
    (longest_seen != '0) |-> (word_count != '0))
    else $error("longest length without a counted word");

  // End of string clears the word state for the next string.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == KIND_END) |=>
      (!inside_word && word_count == '0 && longest_seen == '0))
    else $error("state not cleared after end of string");

  // The done beat is always the last result of its input beat.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_DONE) |-> m_tlast)
    else $error("done beat without tlast");

endmodule

`default_nettype wire

### design/wws_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Result queue of the word splitter: takes up to two results a cycle and
// hands out one a cycle while pop is high. Depends on wws_pkg.

module wws_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push0,
  input  wire wws_pkg::result_t    data0,
  input  wire                      push1,
  input  wire wws_pkg::result_t    data1,
  input  wire                      pop,
  output wws_pkg::result_t         head,
  output logic                     not_empty,
  output logic                     room2
);
  import wws_pkg::*;

  result_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_FILL_W-1:0] fill;
  logic [Q_FILL_W-1:0] fill_next;
  logic [Q_PTR_W-1:0]  wr_ptr1;
  logic                do_pop;

  assign wr_ptr1   = wr_ptr + Q_PTR_W'(1);
  assign not_empty = (fill != '0);
  assign room2     = (fill <= Q_FILL_W'(Q_DEPTH - 2));
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_comb begin
    fill_next = fill + Q_FILL_W'(push0) + Q_FILL_W'(push0 && push1) - Q_FILL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push0 && push1) begin
      entries[wr_ptr1] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push0 && push1) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(2);
      end else if (push0) begin
        wr_ptr <= wr_ptr1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

### tb/whitespace_word_splitter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for whitespace_word_splitter: directed rows, then random
// strings under several buffer settings, the last phase without idling.
// Depends on wws_pkg and the whitespace_word_splitter RTL only.

module whitespace_word_splitter_test;
  import wws_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 40;

  typedef struct {
    logic    kind;
    logic [CP_W-1:0] cp;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = KIND_CHAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_BUFFER_BYTES;
  logic [15:0] cfg_data = '0;

  // Tokenizer state as the block should hold it.
  logic [15:0] buf_bytes = 16'd64;
  logic [15:0] buf_slots = 16'd16;
  logic        in_word = 1'b0;
  logic [15:0] word_len = '0;
  logic [15:0] words_seen = '0;
  logic [15:0] longest_len = '0;

  result_t   events_due[$];
  stim_row_t plan[$];
  result_t   seen_evt;
  int        fault_count = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  whitespace_word_splitter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] bump(logic [15:0] a, logic [2:0] inc);
    logic [16:0] s;
    s = {1'b0, a} + 17'(inc);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic is_ws(logic [CP_W-1:0] cp);
    return cp inside {CP_TAB, CP_LF, CP_VT, CP_FF, CP_CR, CP_SPACE};
  endfunction

  function automatic logic [2:0] byte_size(logic [CP_W-1:0] cp);
    if (cp > CP_MAX3) return 3'd4;
    if (cp > CP_MAX2) return 3'd3;
    if (cp > CP_MAX1) return 3'd2;
    return 3'd1;
  endfunction

  function automatic result_t mk(logic [1:0] ev, logic st, logic [15:0] idx,
                                 logic [15:0] off, logic [2:0] len, logic [CP_W-1:0] ch,
                                 logic [15:0] wf, logic [15:0] lw, logic last_flag);
    result_t r;
    r.event_res = ev;
    r.stored = st;
    r.word_index = idx;
    r.byte_offset = off;
    r.byte_length = len;
    r.char_value = ch;
    r.words_found = wf;
    r.longest_word = lw;
    r.last = last_flag;
    return r;
  endfunction

  // The terminator lands at the clamped offset; the length tracked includes it.
  function automatic void close_word(logic last_flag);
    result_t r;
    logic [15:0] total;
    r = '0;
    r.event_res = EV_WORD;
    r.stored = (words_seen < buf_slots) && (buf_bytes != 0);
    r.word_index = words_seen;
    if (buf_bytes != 0)
      r.byte_offset = (word_len >= buf_bytes) ? buf_bytes - 16'd1 : word_len;
    r.last = last_flag;
    events_due.push_back(r);
    total = bump(word_len, 3'd1);
    if (total > longest_len) longest_len = total;
    words_seen = bump(words_seen, 3'd1);
    word_len = '0;
    in_word = 1'b0;
  endfunction

  function automatic void tokenize_item(logic kind, logic [CP_W-1:0] cp);
    result_t r;
    logic [2:0] sz;
    r = '0;
    if (kind == KIND_END) begin
      if (in_word) close_word(1'b0);
      r.event_res = EV_DONE;
      r.words_found = words_seen;
      r.longest_word = longest_len;
      r.last = 1'b1;
      events_due.push_back(r);
      in_word = 1'b0;
      word_len = '0;
      words_seen = '0;
      longest_len = '0;
    end else if (is_ws(cp)) begin
      if (in_word) begin
        close_word(1'b1);
      end else begin
        r.event_res = EV_SPACE;
        r.word_index = words_seen;
        r.byte_offset = word_len;
        r.char_value = cp;
        r.last = 1'b1;
        events_due.push_back(r);
      end
    end else begin
      sz = byte_size(cp);
      r.event_res = EV_CHAR;
      r.word_index = words_seen;
      r.byte_offset = word_len;
      r.byte_length = sz;
      r.char_value = cp;
      r.last = 1'b1;
      word_len = bump(word_len, sz);
      // The end offset of the character must still fit inside the buffer.
      r.stored = (words_seen < buf_slots) && (word_len < buf_bytes);
      events_due.push_back(r);
      in_word = 1'b1;
    end
  endfunction

  function automatic string fmt_event(result_t r);
    return $sformatf("ev=%0d st=%0d idx=%0d off=%0d len=%0d ch=%h words=%0d longest=%0d last=%0d",
                     r.event_res, r.stored, r.word_index, r.byte_offset, r.byte_length,
                     r.char_value, r.words_found, r.longest_word, r.last);
  endfunction

  function automatic void compare_event(result_t got, result_t want, logic [6:0] pad);
    string diff;
    diff = "";
    if (got.event_res != want.event_res) diff = {diff, " event_res"};
    if (got.stored != want.stored) diff = {diff, " stored"};
    if (got.word_index != want.word_index) diff = {diff, " word_index"};
    if (got.byte_offset != want.byte_offset) diff = {diff, " byte_offset"};
    if (got.byte_length != want.byte_length) diff = {diff, " byte_length"};
    if (got.char_value != want.char_value) diff = {diff, " char_value"};
    if (got.words_found != want.words_found) diff = {diff, " words_found"};
    if (got.longest_word != want.longest_word) diff = {diff, " longest_word"};
    if (got.last != want.last) diff = {diff, " last"};
    if (pad != '0) diff = {diff, " padding"};
    if (diff != "") begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("mismatch in%s at cycle %0d", diff, cycles);
        $display("  expected %s", fmt_event(want));
        $display("  actual   %s", fmt_event(got));
      end
    end
  endfunction

  // Output side: random stall bursts, and a check of every beat taken.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end

    if (!rst && m_tvalid && m_tready) begin
      seen_evt = mk(m_tuser, m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[35:33],
                    m_tdata[56:36], m_tdata[72:57], m_tdata[88:73], m_tlast);
      if (events_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("output beat with nothing expected: %s", fmt_event(seen_evt));
      end else begin
        compare_event(seen_evt, events_due.pop_front(), m_tdata[95:89]);
      end
    end
  end

  function automatic logic [CP_W-1:0] pick_space();
    case ($urandom_range(0, 5))
      0: return CP_TAB;
      1: return CP_LF;
      2: return CP_VT;
      3: return CP_FF;
      4: return CP_CR;
      default: return CP_SPACE;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_char();
    logic [CP_W-1:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cp = CP_W'($urandom_range(8'h21, 8'h7E));
      4: cp = CP_W'($urandom_range(0, 8'h7F));
      5: cp = CP_W'($urandom_range(8'h80, 11'h7FF));
      6: cp = CP_W'($urandom_range(12'h800, 16'hFFFF));
      7: cp = CP_W'($urandom_range(17'h10000, 21'h1FFFFF));
      8: cp = CP_W'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0: cp = CP_MAX1;
          1: cp = CP_MAX1 + 1'b1;
          2: cp = CP_MAX2;
          3: cp = CP_MAX2 + 1'b1;
          4: cp = CP_MAX3;
          5: cp = CP_MAX3 + 1'b1;
          default: cp = '1;
        endcase
      end
    endcase
    if (is_ws(cp)) cp = 21'h2D;
    return cp;
  endfunction

  task automatic send(input logic kind, input logic [CP_W-1:0] cp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {3'b000, cp};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    tokenize_item(kind, cp);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_buffers(input logic [15:0] nbytes, input logic [15:0] nslots);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BUFFER_BYTES;
    cfg_data <= nbytes;
    do @(posedge clk); while (!cfg_ready);
    buf_bytes = nbytes;
    cfg_index <= CFG_BUFFER_SLOTS;
    cfg_data <= nslots;
    do @(posedge clk); while (!cfg_ready);
    buf_slots = nslots;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed text: words of random characters split by whitespace runs,
  // with stray characters and early ends of string mixed in.
  task automatic send_string();
    int nwords;
    int len;
    if ($urandom_range(0, 3) == 0) send(KIND_CHAR, pick_space());
    nwords = $urandom_range(1, 24);
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(0, 9) == 0)
        send(($urandom_range(0, 15) == 0) ? KIND_END : KIND_CHAR, CP_W'($urandom));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      repeat (len) send(KIND_CHAR, pick_char());
      if (w < nwords - 1 || $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) send(KIND_CHAR, pick_space());
    end
    send(KIND_END, CP_W'($urandom));
  endtask

  function automatic void add_row(logic kind, logic [CP_W-1:0] cp, bit typed = 1'b0,
                                  result_t want = '0);
    stim_row_t r;
    r.kind = kind;
    r.cp = cp;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  initial begin
    logic [15:0] settings[10][2];
    int goal;

    settings = '{'{16'd64, 16'd16}, '{16'd0, 16'd16}, '{16'd1, 16'd2}, '{16'd3, 16'd0},
                 '{16'hFFFF, 16'hFFFF}, '{16'd0, 16'd0}, '{16'd7, 16'd1},
                 '{16'hFFFF, 16'd3}, '{16'd12, 16'hFFFF}, '{16'd2, 16'd5}};

    // Rows right after reset, under the reset buffer settings.
    add_row(KIND_END, '0, 1'b1, mk(EV_DONE, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(KIND_CHAR, CP_SPACE, 1'b1, mk(EV_SPACE, 0, 0, 0, 0, CP_SPACE, 0, 0, 1));
    add_row(KIND_CHAR, '1, 1'b1, mk(EV_CHAR, 1, 0, 0, 4, 21'h1FFFFF, 0, 0, 1));
    add_row(KIND_CHAR, CP_SPACE, 1'b1, mk(EV_WORD, 1, 0, 4, 0, 0, 0, 0, 1));
    add_row(KIND_END, '0, 1'b1, mk(EV_DONE, 0, 0, 0, 0, 0, 1, 5, 1));
    add_row(KIND_CHAR, CP_TAB);
    add_row(KIND_CHAR, CP_LF);
    add_row(KIND_CHAR, CP_VT);
    add_row(KIND_CHAR, CP_FF);
    add_row(KIND_CHAR, CP_CR);
    add_row(KIND_CHAR, '0);
    add_row(KIND_CHAR, CP_MAX1);
    add_row(KIND_CHAR, CP_MAX1 + 1'b1);
    add_row(KIND_CHAR, CP_MAX2);
    add_row(KIND_CHAR, CP_MAX2 + 1'b1);
    add_row(KIND_CHAR, CP_MAX3);
    add_row(KIND_CHAR, CP_MAX3 + 1'b1);
    add_row(KIND_CHAR, 21'h08);
    add_row(KIND_CHAR, 21'h0E);
    add_row(KIND_CHAR, 21'h1F);
    add_row(KIND_CHAR, 21'h21);
    add_row(KIND_CHAR, CP_CR);
    add_row(KIND_CHAR, 21'h61);
    // An open word closes before the string ends; the code point is ignored.
    add_row(KIND_END, '1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send(plan[i].kind, plan[i].cp);
      if (plan[i].typed) begin
        void'(events_due.pop_back());
        events_due.push_back(plan[i].want);
      end
    end
    drain();

    for (int p = 0; p < 10; p++) begin
      program_buffers(settings[p][0], settings[p][1]);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_string();
      drain();
    end

    // No idling from here on.
    calm = 1'b1;
    program_buffers(16'd5, 16'd4);
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) send_string();
    drain();

    repeat (8) @(posedge clk);
    if (fault_count == 0 && events_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
